FILE: src/erm_pkg.sv
package erm_pkg;

  // Field widths.
  localparam int AngW = 21;
  localparam int EntW = 16;

  // Cycles from an accepted beat to the sine/cosine outputs of one unit.
  localparam int ScLat = 13;
  // Cycles from an accepted beat to the result strobe.
  localparam int Lat = 16;

  // Q2.14 unit value.
  localparam int One14 = 16384;

  typedef logic signed [AngW-1:0] ang_t;
  typedef logic signed [EntW-1:0] ent_t;

endpackage

FILE: src/erm_sincos.sv
module erm_sincos (
  input  logic          clk_i,
  input  erm_pkg::ang_t angle_i,
  output erm_pkg::ent_t sin_o,
  output erm_pkg::ent_t cos_o
);
  import erm_pkg::*;

  typedef logic [36:0] fx_t;

  typedef struct packed {
    logic [1:0] quad;
    logic       swap;
  } ctl_t;

  // pi/11520 (one step in radians) scaled by 2^48.
  localparam logic [36:0] KStep = 37'h11DF46A253;
  localparam fx_t FxOne = 37'h10_0000_0000;

  // Taylor coefficients 1/n! in Q0.36.
  localparam fx_t C13 = 37'd11;
  localparam fx_t C14 = 37'd1;
  localparam fx_t SinC [6] = '{37'd1722, 37'd189372, 37'd13634817,
                               37'd572662306, 37'd11453246123, FxOne};
  localparam fx_t CosC [6] = '{37'd143, 37'd18937, 37'd1704352,
                               37'd95443718, 37'd2863311531, 37'd34359738368};

  // Rounded Q0.36 product.
  function automatic fx_t mul36(input fx_t a, input fx_t b);
    logic [73:0] p;
    p = 74'(a) * 74'(b) + 74'(64'h8_0000_0000);
    return p[72:36];
  endfunction

  // Stage 1: offset the angle positive and estimate the turn count.
  logic signed [22:0] u_s;
  logic [27:0]        qt_prod;
  logic [21:0]        u_q;
  logic [6:0]         qt_q;

  assign u_s     = 23'(angle_i) + 23'sd1059840;
  assign qt_prod = 28'(u_s[21:9]) * 28'd23302;

  always_ff @(posedge clk_i) begin
    u_q  <= u_s[21:0];
    qt_q <= qt_prod[26:20];
  end

  // Stage 2: remainder modulo one turn.
  logic [21:0] m_full;
  logic [14:0] m_q;

  assign m_full = u_q - 22'(qt_q) * 22'd23040;

  always_ff @(posedge clk_i) begin
    m_q <= m_full[14:0];
  end

  // Stage 3: quadrant and fold into the first octant.
  logic [12:0] r_quad;
  logic [11:0] r_oct;
  ctl_t        ctl_d;
  logic [11:0] r_q;
  ctl_t        ctl_q [10];

  always_comb begin
    priority if (m_q < 15'd5760) begin
      ctl_d.quad = 2'd0;
      r_quad     = m_q[12:0];
    end else if (m_q < 15'd11520) begin
      ctl_d.quad = 2'd1;
      r_quad     = 13'(m_q - 15'd5760);
    end else if (m_q < 15'd17280) begin
      ctl_d.quad = 2'd2;
      r_quad     = 13'(m_q - 15'd11520);
    end else begin
      ctl_d.quad = 2'd3;
      r_quad     = 13'(m_q - 15'd17280);
    end
    ctl_d.swap = (r_quad > 13'd2880);
    r_oct      = ctl_d.swap ? 12'(13'd5760 - r_quad) : r_quad[11:0];
  end

  always_ff @(posedge clk_i) begin
    r_q      <= r_oct;
    ctl_q[0] <= ctl_d;
    for (int i = 1; i < 10; i++) begin
      ctl_q[i] <= ctl_q[i-1];
    end
  end

  // Stage 4: angle in radians, Q0.36.
  logic [48:0] x48;
  logic [49:0] x_rnd;
  fx_t         x_q [8];

  assign x48   = 49'(r_q) * 49'(KStep);
  assign x_rnd = 50'(x48) + 50'd2048;

  always_ff @(posedge clk_i) begin
    x_q[0] <= x_rnd[48:12];
    for (int i = 1; i < 8; i++) begin
      x_q[i] <= x_q[i-1];
    end
  end

  // Stage 5: square of the angle.
  fx_t x2_q [7];

  always_ff @(posedge clk_i) begin
    x2_q[0] <= mul36(x_q[0], x_q[0]);
    for (int i = 1; i < 7; i++) begin
      x2_q[i] <= x2_q[i-1];
    end
  end

  // Stages 6 to 11: Horner steps of both series, one coefficient per stage.
  fx_t hs_q [6];
  fx_t hc_q [6];

  always_ff @(posedge clk_i) begin
    hs_q[0] <= SinC[0] - mul36(x2_q[0], C13);
    hc_q[0] <= CosC[0] - mul36(x2_q[0], C14);
    for (int i = 1; i < 6; i++) begin
      hs_q[i] <= SinC[i] - mul36(x2_q[i], hs_q[i-1]);
      hc_q[i] <= CosC[i] - mul36(x2_q[i], hc_q[i-1]);
    end
  end

  // Stage 12: final multiply of each series.
  fx_t s36_q;
  fx_t c36_q;

  always_ff @(posedge clk_i) begin
    s36_q <= mul36(x_q[7], hs_q[5]);
    c36_q <= FxOne - mul36(x2_q[6], hc_q[5]);
  end

  // Stage 13: round to Q2.14 and apply octant swap and quadrant signs.
  logic [37:0] s_rnd;
  logic [37:0] c_rnd;
  ent_t        s14;
  ent_t        c14;
  ent_t        s0;
  ent_t        c0;
  ent_t        sin_q;
  ent_t        cos_q;

  assign s_rnd = 38'(s36_q) + 38'd2097152;
  assign c_rnd = 38'(c36_q) + 38'd2097152;
  assign s14   = EntW'(s_rnd[37:22]);
  assign c14   = EntW'(c_rnd[37:22]);
  assign s0    = ctl_q[9].swap ? c14 : s14;
  assign c0    = ctl_q[9].swap ? s14 : c14;

  always_ff @(posedge clk_i) begin
    unique case (ctl_q[9].quad)
      2'd0: begin
        sin_q <= s0;
        cos_q <= c0;
      end
      2'd1: begin
        sin_q <= c0;
        cos_q <= -s0;
      end
      2'd2: begin
        sin_q <= -s0;
        cos_q <= -c0;
      end
      default: begin
        sin_q <= -c0;
        cos_q <= s0;
      end
    endcase
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

FILE: src/euler_rotation_matrix_core.sv
// Euler rotation matrix R = Rx*Ry*Rz from three angles in 1/64 degree.
// A beat is taken whenever start is high; busy never rises, so a new angle
// triple may enter on every clock. The nine Q2.14 entries leave the
// pipeline for one cycle with valid_o high, in the order the beats came in;
// the receiver cannot stall and must take each result on that cycle.
// The pipeline is the sine/cosine pipeline (13 stages: angle reduction,
// scaling to radians, a polynomial evaluation and rounding with quadrant
// signs) followed by three stages of entry products, sums and rounding.
module euler_rotation_matrix_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  erm_pkg::ang_t angle_z_i,
  input  erm_pkg::ang_t angle_x_i,
  input  erm_pkg::ang_t angle_y_i,
  output logic          valid_o,
  output erm_pkg::ent_t r00_o,
  output erm_pkg::ent_t r01_o,
  output erm_pkg::ent_t r02_o,
  output erm_pkg::ent_t r10_o,
  output erm_pkg::ent_t r11_o,
  output erm_pkg::ent_t r12_o,
  output erm_pkg::ent_t r20_o,
  output erm_pkg::ent_t r21_o,
  output erm_pkg::ent_t r22_o
);
  import erm_pkg::*;

  typedef logic signed [31:0] p2_t;
  typedef logic signed [47:0] p3_t;
  typedef logic signed [49:0] acc_t;

  // Round a Q.42 sum to Q2.14 with ties up, then saturate to plus/minus one.
  function automatic ent_t rnd_sat(input acc_t v);
    acc_t t;
    t = (v + acc_t'(64'sd134217728)) >>> 28;
    if (t > acc_t'(One14)) begin
      return ent_t'(One14);
    end else if (t < -acc_t'(One14)) begin
      return ent_t'(-One14);
    end
    return ent_t'(t);
  endfunction

  // Valid bits alongside the data pipeline.
  logic [Lat-1:0] vld_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start};
    end
  end

  // Sine and cosine of each angle.
  ent_t sz, cz, sx, cx, sy, cy;

  erm_sincos u_sc_z (.clk_i(clk_i), .angle_i(angle_z_i), .sin_o(sz), .cos_o(cz));
  erm_sincos u_sc_x (.clk_i(clk_i), .angle_i(angle_x_i), .sin_o(sx), .cos_o(cx));
  erm_sincos u_sc_y (.clk_i(clk_i), .angle_i(angle_y_i), .sin_o(sy), .cos_o(cy));

  // Stage 14: pairwise products.
  p2_t  cycz_q, cysz_q, sxcy_q, cxcy_q, cxsz_q, cxcz_q, sxsz_q, sxcz_q;
  p2_t  sycz_q, sysz_q;
  ent_t sy_q, sx_q, cx_q;

  always_ff @(posedge clk_i) begin
    cycz_q <= p2_t'(cy) * p2_t'(cz);
    cysz_q <= p2_t'(cy) * p2_t'(sz);
    sxcy_q <= p2_t'(sx) * p2_t'(cy);
    cxcy_q <= p2_t'(cx) * p2_t'(cy);
    cxsz_q <= p2_t'(cx) * p2_t'(sz);
    cxcz_q <= p2_t'(cx) * p2_t'(cz);
    sxsz_q <= p2_t'(sx) * p2_t'(sz);
    sxcz_q <= p2_t'(sx) * p2_t'(cz);
    sycz_q <= p2_t'(sy) * p2_t'(cz);
    sysz_q <= p2_t'(sy) * p2_t'(sz);
    sy_q   <= sy;
    sx_q   <= sx;
    cx_q   <= cx;
  end

  // Stage 15: triple products; pairwise terms move to Q.42.
  p3_t  t10_q, t11_q, t20_q, t21_q;
  acc_t a00_q, a01_q, a02_q, a10_q, a11_q, a12_q, a20_q, a21_q, a22_q;

  always_ff @(posedge clk_i) begin
    t10_q <= p3_t'(sx_q) * p3_t'(sycz_q);
    t11_q <= p3_t'(sx_q) * p3_t'(sysz_q);
    t20_q <= p3_t'(cx_q) * p3_t'(sycz_q);
    t21_q <= p3_t'(cx_q) * p3_t'(sysz_q);
    a00_q <= acc_t'(cycz_q) <<< 14;
    a01_q <= -(acc_t'(cysz_q) <<< 14);
    a02_q <= acc_t'(sy_q) <<< 28;
    a10_q <= acc_t'(cxsz_q) <<< 14;
    a11_q <= acc_t'(cxcz_q) <<< 14;
    a12_q <= -(acc_t'(sxcy_q) <<< 14);
    a20_q <= acc_t'(sxsz_q) <<< 14;
    a21_q <= acc_t'(sxcz_q) <<< 14;
    a22_q <= acc_t'(cxcy_q) <<< 14;
  end

  // Stage 16: sums, rounding and saturation into the output registers.
  ent_t r00_q, r01_q, r02_q, r10_q, r11_q, r12_q, r20_q, r21_q, r22_q;

  always_ff @(posedge clk_i) begin
    r00_q <= rnd_sat(a00_q);
    r01_q <= rnd_sat(a01_q);
    r02_q <= rnd_sat(a02_q);
    r10_q <= rnd_sat(a10_q + acc_t'(t10_q));
    r11_q <= rnd_sat(a11_q - acc_t'(t11_q));
    r12_q <= rnd_sat(a12_q);
    r20_q <= rnd_sat(a20_q - acc_t'(t20_q));
    r21_q <= rnd_sat(a21_q + acc_t'(t21_q));
    r22_q <= rnd_sat(a22_q);
  end

  assign valid_o = vld_q[Lat-1];
  assign r00_o   = r00_q;
  assign r01_o   = r01_q;
  assign r02_o   = r02_q;
  assign r10_o   = r10_q;
  assign r11_o   = r11_q;
  assign r12_o   = r12_q;
  assign r20_o   = r20_q;
  assign r21_o   = r21_q;
  assign r22_o   = r22_q;

endmodule

FILE: src/erm_chk.sv
module erm_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input erm_pkg::ang_t angle_z_i,
  input erm_pkg::ang_t angle_x_i,
  input erm_pkg::ang_t angle_y_i,
  input logic          valid_o,
  input erm_pkg::ent_t r00_o,
  input erm_pkg::ent_t r02_o
);
  import erm_pkg::*;

  // The block never holds off a beat.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // Every accepted beat yields a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##16 valid_o)
    else $error("result missing");

  // No result appears without a beat accepted the latency earlier.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, 16))
    else $error("spurious result");

  // The sine entry stays within plus/minus one.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (r02_o <= ent_t'(One14)) && (r02_o >= ent_t'(-One14)))
    else $error("entry out of range");

  // Zero angles give the identity in the first entry.
  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && angle_z_i == '0 && angle_x_i == '0 && angle_y_i == '0)
      |-> ##16 (r00_o == ent_t'(One14)))
    else $error("identity entry wrong");

endmodule

bind euler_rotation_matrix_core erm_chk u_erm_chk (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .start(start),
  .busy(busy),
  .angle_z_i(angle_z_i),
  .angle_x_i(angle_x_i),
  .angle_y_i(angle_y_i),
  .valid_o(valid_o),
  .r00_o(r00_o),
  .r02_o(r02_o)
);

FILE: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import erm_pkg::*;

  localparam int Turn = 23040;
  localparam int Quad = 5760;
  localparam int Oct = 2880;
  localparam int CycleLimit = 200000;

  typedef struct {
    ent_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } rot_mat_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  ang_t angle_z_i, angle_x_i, angle_y_i;
  logic valid_o;
  ent_t r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o;

  rot_mat_t pending_mats[$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;

  // Sine and cosine in Q2.14 for the first octant, steps 0..2880.
  int oct_sin[0:Oct];
  int oct_cos[0:Oct];

  euler_rotation_matrix_core uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .angle_z_i(angle_z_i),
    .angle_x_i(angle_x_i),
    .angle_y_i(angle_y_i),
    .valid_o  (valid_o),
    .r00_o    (r00_o),
    .r01_o    (r01_o),
    .r02_o    (r02_o),
    .r10_o    (r10_o),
    .r11_o    (r11_o),
    .r12_o    (r12_o),
    .r20_o    (r20_o),
    .r21_o    (r21_o),
    .r22_o    (r22_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #2 clk_i = ~clk_i;
  end

  // Truncating product of two Q4.60 values.
  function automatic longint unsigned q60_mul(longint unsigned a, longint unsigned b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // Arctangent of 1/n in Q60, by its series.
  function automatic longint unsigned q60_atan_inv(longint unsigned n);
    longint unsigned term, acc;
    term = (64'd1 << 60) / n;
    acc = term;
    for (int k = 1; k < 64; k++) begin
      term = term / (n * n);
      if (term == 0) break;
      if (k % 2 == 1) acc = acc - term / (2 * k + 1);
      else acc = acc + term / (2 * k + 1);
    end
    return acc;
  endfunction

  function automatic int q60_to_q14(longint unsigned v);
    return int'((v + (64'd1 << 45)) >> 46);
  endfunction

  // Fill the first-octant tables with Taylor series in Q60.
  task automatic build_octant_tables();
    longint unsigned pi_q60, x, x2, ts, tc, sum_s, sum_c;
    pi_q60 = 16 * q60_atan_inv(5) - 4 * q60_atan_inv(239);
    for (int r = 0; r <= Oct; r++) begin
      x = (pi_q60 / 11520) * r;
      x2 = q60_mul(x, x);
      ts = x;
      sum_s = x;
      tc = 64'd1 << 60;
      sum_c = tc;
      for (int k = 1; k < 32; k++) begin
        ts = q60_mul(ts, x2) / ((2 * k) * (2 * k + 1));
        tc = q60_mul(tc, x2) / ((2 * k - 1) * (2 * k));
        if (k % 2 == 1) begin
          sum_s = sum_s - ts;
          sum_c = sum_c - tc;
        end else begin
          sum_s = sum_s + ts;
          sum_c = sum_c + tc;
        end
        if (ts == 0 && tc == 0) break;
      end
      oct_sin[r] = q60_to_q14(sum_s);
      oct_cos[r] = q60_to_q14(sum_c);
    end
  endtask

  // Sine and cosine of an angle by octant folding and quadrant signs.
  task automatic angle_sin_cos(input ang_t ang, output int s, output int c);
    int m, q, r, s0, c0;
    m = int'(ang) % Turn;
    if (m < 0) m += Turn;
    q = m / Quad;
    r = m % Quad;
    if (r <= Oct) begin
      s0 = oct_sin[r];
      c0 = oct_cos[r];
    end else begin
      s0 = oct_cos[Quad - r];
      c0 = oct_sin[Quad - r];
    end
    case (q)
      0: begin s = s0; c = c0; end
      1: begin s = c0; c = -s0; end
      2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endtask

  // Round a Q.42 sum to Q2.14 with ties upward, then saturate.
  function automatic ent_t q42_to_entry(longint v);
    longint biased, e;
    biased = v + (64'sd1 <<< 45) + (64'sd1 <<< 27);
    e = (biased >>> 28) - (64'sd1 <<< 17);
    if (e > One14) e = One14;
    if (e < -One14) e = -One14;
    return ent_t'(e);
  endfunction

  function automatic longint prod2(int a, int b);
    return longint'(a) * longint'(b) * One14;
  endfunction

  function automatic longint prod3(int a, int b, int c);
    return longint'(a) * longint'(b) * longint'(c);
  endfunction

  task automatic predict_rotation(input ang_t az, input ang_t ax, input ang_t ay,
                                  output rot_mat_t m);
    int sz, cz, sx, cx, sy, cy;
    angle_sin_cos(az, sz, cz);
    angle_sin_cos(ax, sx, cx);
    angle_sin_cos(ay, sy, cy);
    m.m00 = q42_to_entry(prod2(cy, cz));
    m.m01 = q42_to_entry(-prod2(cy, sz));
    m.m02 = q42_to_entry(prod2(sy, One14));
    m.m10 = q42_to_entry(prod2(cx, sz) + prod3(sx, sy, cz));
    m.m11 = q42_to_entry(prod2(cx, cz) - prod3(sx, sy, sz));
    m.m12 = q42_to_entry(-prod2(sx, cy));
    m.m20 = q42_to_entry(prod2(sx, sz) - prod3(cx, sy, cz));
    m.m21 = q42_to_entry(prod2(sx, cz) + prod3(cx, sy, sz));
    m.m22 = q42_to_entry(prod2(cx, cy));
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("tb: mismatch %s got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
    mismatch_cnt++;
  endtask

  // Send one beat: hold start until it is taken at an edge with busy low.
  task automatic send_angles(input ang_t az, input ang_t ax, input ang_t ay);
    rot_mat_t m;
    start <= 1'b1;
    angle_z_i <= az;
    angle_x_i <= ax;
    angle_y_i <= ay;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    predict_rotation(az, ax, ay, m);
    pending_mats.push_back(m);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Check each result beat against the oldest prediction.
  always @(posedge clk_i) begin
    rot_mat_t m;
    if (rst_ni && valid_o) begin
      if (pending_mats.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        m = pending_mats.pop_front();
        if (r00_o !== m.m00) report_mismatch("r00", r00_o, m.m00);
        if (r01_o !== m.m01) report_mismatch("r01", r01_o, m.m01);
        if (r02_o !== m.m02) report_mismatch("r02", r02_o, m.m02);
        if (r10_o !== m.m10) report_mismatch("r10", r10_o, m.m10);
        if (r11_o !== m.m11) report_mismatch("r11", r11_o, m.m11);
        if (r12_o !== m.m12) report_mismatch("r12", r12_o, m.m12);
        if (r20_o !== m.m20) report_mismatch("r20", r20_o, m.m20);
        if (r21_o !== m.m21) report_mismatch("r21", r21_o, m.m21);
        if (r22_o !== m.m22) report_mismatch("r22", r22_o, m.m22);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Extremes, quadrant and octant boundaries, and wrap points.
  task automatic test_directed();
    int pts[] = '{0, Oct, Oct + 1, Oct - 1, Quad, 2 * Quad, 3 * Quad, Turn - 1, Turn,
                  -1, -Quad, 1048575, -1048576, 1, 2 * Oct + 1};
    foreach (pts[i]) send_angles(ang_t'(pts[i]), ang_t'(pts[(i + 5) % pts.size()]),
                                 ang_t'(pts[(i + 9) % pts.size()]));
    send_angles(ang_t'(1048575), ang_t'(1048575), ang_t'(1048575));
    send_angles(ang_t'(-1048576), ang_t'(-1048576), ang_t'(-1048576));
    send_angles(ang_t'(Oct), ang_t'(Oct), ang_t'(Oct));
    send_angles(ang_t'(-Oct), ang_t'(3 * Oct), ang_t'(5 * Oct));
    idle_cycles(1);
  endtask

  function automatic ang_t rand_angle();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return ang_t'($urandom);
    if (sel < 8) return ang_t'($urandom_range(0, Turn - 1));
    return ang_t'(int'($urandom_range(0, 72)) * Oct - 36 * Oct + int'($urandom_range(0, 2)) - 1);
  endfunction

  // Random angles sent in bursts with random gaps.
  task automatic test_random_bursts(input int n_beats);
    int sent, burst;
    sent = 0;
    while (sent < n_beats) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < n_beats; i++) begin
        send_angles(rand_angle(), rand_angle(), rand_angle());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
    idle_cycles(1);
  endtask

  // Let the pipeline drain completely before more beats go in.
  task automatic test_drain_pause();
    start <= 1'b0;
    while (pending_mats.size() != 0) @(posedge clk_i);
    test_random_bursts(50);
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    angle_z_i = '0;
    angle_x_i = '0;
    angle_y_i = '0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    build_octant_tables();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_bursts(900);
    test_drain_pause();
    test_random_bursts(850);
    while (pending_mats.size() != 0) @(posedge clk_i);
    repeat (Lat + 4) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_mats.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
